/* hw/rtl/dits_pkg.sv */
// Shared types, constants and codes for the dock identification and touch select block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package dits_pkg;

    // Block dimensions
    localparam int NUM_DOCKS        = 8;
    localparam int NUM_STAGES       = 6;
    localparam int SAMPLES_PER_READ = 8;   // a power of two: the average is a shift
    localparam int NUM_CODE_REGS    = 6;

    // Field widths
    localparam int ADC_W     = 10;
    localparam int DOCK_W    = 3;
    localparam int STAGE_W   = 3;
    localparam int TOUCH_W   = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Accumulator sizing
    localparam int AVG_SHIFT = $clog2(SAMPLES_PER_READ);
    localparam int SUM_W     = ADC_W + AVG_SHIFT;
    localparam int CNT_W     = $clog2(SAMPLES_PER_READ + 1);

    typedef logic [DOCK_W-1:0]  dock_t;
    typedef logic [STAGE_W-1:0] stage_t;
    typedef logic [ADC_W-1:0]   code_t;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TOUCH  = 1'b1;

    // Event kinds
    localparam logic EV_CHANGE = 1'b0;
    localparam logic EV_TOUCH  = 1'b1;

    // Touch modes (any other code leaves the flags alone)
    localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP   = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_CODE_0 = 3'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHANGE,
        ST_SCAN
    } state_t;

    // One result item
    typedef struct packed {
        logic   event_kind;
        dock_t  dock_out;
        stage_t prev_stage;
        stage_t stage_out;
        logic   released;
        logic   stage_selected;
        logic   last_result;
    } result_t;

    // Status of the nearest-code search unit
    typedef struct packed {
        logic   done;
        stage_t stage;
    } search_stat_t;

endpackage

/* hw/rtl/dits_nearest.sv */
// Iterative nearest-code search: one absolute difference and compare per cycle.
// Depends on dits_pkg.
`timescale 1ns / 1ps

module dits_nearest
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  dits_pkg::code_t                               avg,
    input  logic [dits_pkg::NUM_STAGES-1:0][dits_pkg::ADC_W-1:0] codes,
    output dits_pkg::search_stat_t                        stat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    dits_pkg::stage_t idx_reg, idx_next;
    dits_pkg::stage_t best_reg, best_next;
    dits_pkg::code_t  best_dist_reg, best_dist_next;

    dits_pkg::code_t  code_sel;
    dits_pkg::code_t  code_gap;
    logic             better;

    // Distance of the current stage code to the average
    always_comb
    begin
        code_sel = codes[idx_reg];
        code_gap = (code_sel > avg) ? (code_sel - avg) : (avg - code_sel);
        // the first stage always wins, later ones only when strictly closer
        better   = (idx_reg == '0) || (code_gap < best_dist_reg);
    end

    // Step through the stages
    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = 1'b0;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (better)
            begin
                best_next      = idx_reg;
                best_dist_next = code_gap;
            end
            if (idx_reg == dits_pkg::STAGE_W'(dits_pkg::NUM_STAGES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    // Hold the best candidate
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
    end

    assign stat = '{done: done_reg, stage: best_reg};

endmodule

/* hw/rtl/dits_out_reg.sv */
// Output register for result items towards the master-side stream.
// Depends on dits_pkg.
`timescale 1ns / 1ps

module dits_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dits_pkg::result_t din,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dits_pkg::result_t dout
);

    logic              valid_reg, valid_next;
    dits_pkg::result_t data_reg;

    // Slot is free when empty or being drained this cycle
    always_comb
    begin
        free = !valid_reg || m_tready;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign m_tvalid = valid_reg;
    assign dout     = data_reg;

endmodule

/* hw/rtl/dock_id_and_touch_select.sv */
// Top level of the dock identification and touch select block: sequencer and state.
// Depends on dits_pkg, dits_nearest and dits_out_reg.
`timescale 1ns / 1ps

// One request at a time. An ADC sample that does not complete a reading starts no search.
// A sample that completes a reading of SAMPLES_PER_READ samples starts the nearest-code
// search, which walks the stage codes one per cycle through a single subtract and compare
// unit; when the dock changes stage, a change result is then sent once it has waited for
// a free output register. A touch scan request with no changed electrode only records the
// touch bits; otherwise the scan steps through the docks up to and including the highest
// changed one, and each changed dock waits for a free output register for its result.
// One result leaves per cycle at most.
// Configuration writes are always accepted and should only be made while idle.
module dock_id_and_touch_select
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // dock_index[2:0], adc_sample[12:3], touch_bits[20:13]
    input  logic [0:0]  s_tuser,   // req_type[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // dock_out[2:0], prev_stage[5:3], stage_out[8:6],
                                   // released[9], stage_selected[10]
    output logic [0:0]  m_tuser,   // event_kind[0]
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int NS = dits_pkg::NUM_STAGES;
    localparam int ND = dits_pkg::NUM_DOCKS;
    localparam int TW = dits_pkg::TOUCH_W;

    dits_pkg::state_t state_reg, state_next;

    // configuration
    logic [dits_pkg::MODE_W-1:0]                   touch_mode_reg;
    logic [dits_pkg::NUM_CODE_REGS-1:0][dits_pkg::ADC_W-1:0] code_reg;

    // block state
    logic [dits_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [dits_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ND-1:0][dits_pkg::STAGE_W-1:0] dock_stage_reg, dock_stage_next;
    logic [NS-1:0]              flags_reg, flags_next;
    logic [TW-1:0]              last_touch_reg, last_touch_next;
    logic                       start_reg, start_next;

    // per-request working registers
    dits_pkg::dock_t  dock_reg, dock_next;
    dits_pkg::code_t  avg_reg, avg_next;
    dits_pkg::stage_t cur_reg, cur_next;
    dits_pkg::dock_t  idx_reg, idx_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [TW-1:0]    diff_reg, diff_next;

    // request fields
    logic             in_req;
    dits_pkg::dock_t  in_dock;
    dits_pkg::code_t  in_adc;
    logic [TW-1:0]    in_touch;
    logic             accept;

    logic [dits_pkg::SUM_W-1:0] sum_add;
    logic [dits_pkg::CNT_W-1:0] cnt_inc;
    logic             read_done;
    logic             dock_ok;
    logic [TW-1:0]    dock_mask;
    logic [TW-1:0]    touch_diff;

    dits_pkg::dock_t  rd_dock;
    dits_pkg::stage_t rd_stage;
    dits_pkg::stage_t flag_addr;
    logic             flag_rd;

    logic [TW-1:0]    above_mask;
    logic             scan_edge;
    logic             scan_last;
    logic             scan_adv;
    logic             pressed;
    logic             new_flag;

    dits_pkg::search_stat_t stat;
    logic                   out_load;
    logic                   out_free;
    dits_pkg::result_t      out_din;
    dits_pkg::result_t      out_dout;

    function automatic logic [dits_pkg::CFG_IDX_W-1:0] CFG_OFS(input int i);
        return dits_pkg::CFG_IDX_W'(i);
    endfunction

    // Unpack the request
    assign in_req   = s_tuser[0];
    assign in_dock  = s_tdata[2:0];
    assign in_adc   = s_tdata[12:3];
    assign in_touch = s_tdata[20:13];

    assign s_tready  = (state_reg == dits_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Accumulator arithmetic and touch edge mask
    always_comb
    begin
        sum_add    = sum_reg + dits_pkg::SUM_W'(in_adc);
        cnt_inc    = cnt_reg + 1'b1;
        read_done  = (cnt_inc == dits_pkg::CNT_W'(dits_pkg::SAMPLES_PER_READ));
        dock_ok    = ({1'b0, in_dock} < (dits_pkg::DOCK_W + 1)'(ND));
        for (int i = 0; i < TW; i++)
        begin
            dock_mask[i]  = (i < ND);
            above_mask[i] = ((dits_pkg::DOCK_W + 1)'(i) > {1'b0, idx_reg});
        end
        touch_diff = (in_touch ^ last_touch_reg) & dock_mask;
    end

    // Single read port on the stage table and the flags
    always_comb
    begin
        rd_dock   = (state_reg == dits_pkg::ST_SCAN) ? idx_reg : dock_reg;
        rd_stage  = dock_stage_reg[rd_dock];
        flag_addr = (state_reg == dits_pkg::ST_SCAN) ? rd_stage : cur_reg;
        flag_rd   = flags_reg[flag_addr];
    end

    // Touch scan step for the current dock
    always_comb
    begin
        scan_edge = diff_reg[idx_reg];
        scan_last = ~|(diff_reg & above_mask);
        scan_adv  = !scan_edge || out_free;
        pressed   = now_reg[idx_reg];
        if (touch_mode_reg == dits_pkg::MODE_FOLLOW)
            new_flag = pressed;
        else if (touch_mode_reg == dits_pkg::MODE_FLIP)
            new_flag = pressed ? !flag_rd : flag_rd;
        else
            new_flag = flag_rd;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dits_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == dits_pkg::REQ_SAMPLE)
                    begin
                        if (dock_ok && read_done)
                            state_next = dits_pkg::ST_SEARCH;
                    end
                    else if (touch_diff != '0)
                    begin
                        state_next = dits_pkg::ST_SCAN;
                    end
                end
            end
            dits_pkg::ST_SEARCH:
            begin
                if (stat.done)
                    state_next = (stat.stage != rd_stage) ? dits_pkg::ST_CHANGE
                                                          : dits_pkg::ST_IDLE;
            end
            dits_pkg::ST_CHANGE:
            begin
                if (out_free)
                    state_next = dits_pkg::ST_IDLE;
            end
            dits_pkg::ST_SCAN:
            begin
                if (scan_adv && scan_last)
                    state_next = dits_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dits_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result generation
    always_comb
    begin
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        dock_stage_next = dock_stage_reg;
        flags_next      = flags_reg;
        last_touch_next = last_touch_reg;
        start_next      = 1'b0;
        dock_next       = dock_reg;
        avg_next        = avg_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        diff_next       = diff_reg;
        out_load        = 1'b0;
        out_din         = '0;
        case (state_reg)
            dits_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == dits_pkg::REQ_SAMPLE)
                    begin
                        if (dock_ok)
                        begin
                            dock_next = in_dock;
                            if (read_done)
                            begin
                                avg_next   = sum_add[dits_pkg::AVG_SHIFT +: dits_pkg::ADC_W];
                                sum_next   = '0;
                                cnt_next   = '0;
                                start_next = 1'b1;
                            end
                            else
                            begin
                                sum_next = sum_add;
                                cnt_next = cnt_inc;
                            end
                        end
                    end
                    else
                    begin
                        now_next  = in_touch;
                        diff_next = touch_diff;
                        idx_next  = '0;
                        // no edge: only remember the scan
                        if (touch_diff == '0)
                            last_touch_next = in_touch;
                    end
                end
            end
            dits_pkg::ST_SEARCH:
            begin
                if (stat.done)
                    cur_next = stat.stage;
            end
            dits_pkg::ST_CHANGE:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_din.event_kind       = dits_pkg::EV_CHANGE;
                    out_din.dock_out         = dock_reg;
                    out_din.prev_stage       = rd_stage;
                    out_din.stage_out        = cur_reg;
                    out_din.released         = 1'b0;
                    out_din.stage_selected   = flag_rd;
                    out_din.last_result      = 1'b1;
                    dock_stage_next[dock_reg] = cur_reg;
                    flags_next[rd_stage]     = 1'b0;
                end
            end
            dits_pkg::ST_SCAN:
            begin
                if (scan_edge && out_free)
                begin
                    out_load               = 1'b1;
                    out_din.event_kind     = dits_pkg::EV_TOUCH;
                    out_din.dock_out       = idx_reg;
                    out_din.prev_stage     = '0;
                    out_din.stage_out      = rd_stage;
                    out_din.released       = !pressed;
                    out_din.stage_selected = new_flag;
                    out_din.last_result    = scan_last;
                    flags_next[rd_stage]   = new_flag;
                end
                if (scan_adv)
                begin
                    if (scan_last)
                        last_touch_next = now_reg;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dits_pkg::ST_IDLE;
            touch_mode_reg <= '0;
            code_reg       <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            dock_stage_reg <= '0;
            flags_reg      <= '0;
            last_touch_reg <= '0;
            start_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            dock_stage_reg <= dock_stage_next;
            flags_reg      <= flags_next;
            last_touch_reg <= last_touch_next;
            start_reg      <= start_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dits_pkg::CFG_TOUCH_MODE)
                    touch_mode_reg <= cfg_data[dits_pkg::MODE_W-1:0];
                else
                begin
                    for (int i = 0; i < dits_pkg::NUM_CODE_REGS; i++)
                    begin
                        if (cfg_index == dits_pkg::CFG_STAGE_CODE_0 + CFG_OFS(i))
                            code_reg[i] <= cfg_data;
                    end
                end
            end
        end
    end

    // Per-request working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dock_reg <= '0;
            avg_reg  <= '0;
            cur_reg  <= '0;
            idx_reg  <= '0;
            now_reg  <= '0;
            diff_reg <= '0;
        end
        else
        begin
            dock_reg <= dock_next;
            avg_reg  <= avg_next;
            cur_reg  <= cur_next;
            idx_reg  <= idx_next;
            now_reg  <= now_next;
            diff_reg <= diff_next;
        end
    end

    // Shared search unit
    dits_nearest u_nearest
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .avg   (avg_reg),
        .codes (code_reg[NS-1:0]),
        .stat  (stat)
    );

    // Result register
    dits_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .din      (out_din),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (out_dout)
    );

    // Pack the result
    assign m_tuser[0] = out_dout.event_kind;
    assign m_tlast    = out_dout.last_result;
    assign m_tdata    = {5'b0, out_dout.stage_selected, out_dout.released,
                         out_dout.stage_out, out_dout.prev_stage, out_dout.dock_out};

    // Sample count never reaches a full reading between requests
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < dits_pkg::CNT_W'(dits_pkg::SAMPLES_PER_READ))
        else $error("sample count out of range");

    // Search completes only while the sequencer waits for it
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == dits_pkg::ST_SEARCH))
        else $error("search done outside search state");

    // A stage change clears the selected flag of the stage left behind
    a_change_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dits_pkg::ST_CHANGE && out_free) |=> !flags_reg[$past(rd_stage)])
        else $error("old stage flag not cleared");

    // Stored stages always name a real stage
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_stage < dits_pkg::STAGE_W'(NS))
        else $error("stored stage out of range");

    // A touch result is only produced for a changed electrode
    a_scan_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg == dits_pkg::ST_SCAN) |-> diff_reg[idx_reg])
        else $error("touch result without edge");

endmodule
